// File: rtl/core/qan_pkg.sv
// Shared types and constants for the normalized quaternion ALU.
package qan_pkg;

  // Operation codes; the fourth code gives an all-zero result.
  typedef enum logic [1:0] {
    FUNC_MUL = 2'd0,
    FUNC_ADD = 2'd1,
    FUNC_SUB = 2'd2
  } qan_func_e;

  localparam int unsigned Lanes    = 4;
  localparam int unsigned DivSteps = 33;
  localparam int unsigned IsqSteps = 17;

  localparam int unsigned SqW   = 60;
  localparam int unsigned SumW  = 62;
  localparam int unsigned QuoW  = 33;
  localparam int unsigned RootW = 17;
  localparam int unsigned IsqRemW = 36;

  // Sideband that travels with every item down the pipeline.
  typedef struct packed {
    logic [3:0] neg;
    logic       nop;
    logic       zero;
  } qan_side_t;

endpackage

// File: rtl/core/qan_front.sv
// Front end: raw quaternion result, block shift, squares and their sum.
module qan_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [1:0]            func_i,
  input  logic signed [17:0]    a_x_i,
  input  logic signed [17:0]    a_y_i,
  input  logic signed [17:0]    a_z_i,
  input  logic signed [17:0]    a_w_i,
  input  logic signed [17:0]    b_x_i,
  input  logic signed [17:0]    b_y_i,
  input  logic signed [17:0]    b_z_i,
  input  logic signed [17:0]    b_w_i,
  output logic                  valid_o,
  output logic [3:0][59:0]      sq_o,
  output logic [61:0]           sum_o,
  output qan_pkg::qan_side_t    side_o
);
  import qan_pkg::*;

  // Operand pairs of the sixteen partial products, component order x, y, z, w.
  localparam int IdxA [16] = '{3, 0, 1, 2, 3, 1, 2, 0, 3, 2, 0, 1, 3, 0, 1, 2};
  localparam int IdxB [16] = '{0, 3, 2, 1, 1, 3, 0, 2, 2, 3, 1, 0, 3, 0, 1, 2};

  logic signed [17:0] av [4];
  logic signed [17:0] bv [4];

  assign av[0] = a_x_i;
  assign av[1] = a_y_i;
  assign av[2] = a_z_i;
  assign av[3] = a_w_i;
  assign bv[0] = b_x_i;
  assign bv[1] = b_y_i;
  assign bv[2] = b_z_i;
  assign bv[3] = b_w_i;

  logic [5:0] vld_q;

  // Stage 1: products and sums.
  logic signed [35:0] prod_d [16];
  logic signed [35:0] prod_q [16];
  logic signed [18:0] sd_d [4];
  logic signed [18:0] sd_q [4];
  qan_func_e          func_q;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      prod_d[i] = av[IdxA[i]] * bv[IdxB[i]];
    end
    for (int k = 0; k < 4; k++) begin
      if (func_i == FUNC_SUB) begin
        sd_d[k] = 19'(av[k]) - 19'(bv[k]);
      end else begin
        sd_d[k] = 19'(av[k]) + 19'(bv[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      sd_q   <= sd_d;
      func_q <= qan_func_e'(func_i);
    end
  end

  // Stage 2: raw components at scale 2^-30.
  logic signed [37:0] c_d [4];
  logic signed [37:0] c_q [4];
  logic               nop_d;
  logic               nop2_q;

  always_comb begin
    nop_d = 1'b0;
    for (int k = 0; k < 4; k++) begin
      c_d[k] = '0;
    end
    unique case (func_q)
      FUNC_MUL: begin
        for (int k = 0; k < 3; k++) begin
          c_d[k] = 38'(prod_q[4*k]) + 38'(prod_q[4*k+1]) + 38'(prod_q[4*k+2])
                   - 38'(prod_q[4*k+3]);
        end
        c_d[3] = 38'(prod_q[12]) - 38'(prod_q[13]) - 38'(prod_q[14])
                 - 38'(prod_q[15]);
      end
      FUNC_ADD, FUNC_SUB: begin
        for (int k = 0; k < 4; k++) begin
          c_d[k] = 38'(sd_q[k]) <<< 15;
        end
      end
      default: nop_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q    <= c_d;
      nop2_q <= nop_d;
    end
  end

  // Stage 3: magnitudes and the common shift that brings all below 2^30.
  logic [36:0] mag_d [4];
  logic [36:0] mag_q [4];
  logic [36:0] any_bits;
  logic [2:0]  sh_d;
  logic [2:0]  sh_q;
  logic [3:0]  neg3_q;
  logic        nop3_q;

  always_comb begin
    any_bits = '0;
    for (int k = 0; k < 4; k++) begin
      mag_d[k] = c_q[k][37] ? 37'(-c_q[k]) : 37'(c_q[k]);
      any_bits = any_bits | mag_d[k];
    end
    if (any_bits[36])      sh_d = 3'd7;
    else if (any_bits[35]) sh_d = 3'd6;
    else if (any_bits[34]) sh_d = 3'd5;
    else if (any_bits[33]) sh_d = 3'd4;
    else if (any_bits[32]) sh_d = 3'd3;
    else if (any_bits[31]) sh_d = 3'd2;
    else if (any_bits[30]) sh_d = 3'd1;
    else                   sh_d = 3'd0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      sh_q   <= sh_d;
      nop3_q <= nop2_q;
      for (int k = 0; k < 4; k++) begin
        neg3_q[k] <= c_q[k][37];
      end
    end
  end

  // Stage 4: shifted magnitudes.
  logic [29:0] d_q [4];
  logic [3:0]  neg4_q;
  logic        nop4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        d_q[k] <= 30'(mag_q[k] >> sh_q);
      end
      neg4_q <= neg3_q;
      nop4_q <= nop3_q;
    end
  end

  // Stage 5: squares.
  logic [59:0] sq5_q [4];
  logic [3:0]  neg5_q;
  logic        nop5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        sq5_q[k] <= d_q[k] * d_q[k];
      end
      neg5_q <= neg4_q;
      nop5_q <= nop4_q;
    end
  end

  // Stage 6: sum of squares.
  logic [61:0] sum_d;
  logic [61:0] sum_q;
  logic [59:0] sq6_q [4];
  qan_side_t   side_q;

  assign sum_d = 62'(sq5_q[0]) + 62'(sq5_q[1]) + 62'(sq5_q[2]) + 62'(sq5_q[3]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq6_q       <= sq5_q;
      sum_q       <= sum_d;
      side_q.neg  <= neg5_q;
      side_q.nop  <= nop5_q;
      side_q.zero <= (sum_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sq_o[k] = sq6_q[k];
    end
  end

  assign sum_o   = sum_q;
  assign side_o  = side_q;
  assign valid_o = vld_q[5];

endmodule

// File: rtl/core/qan_div.sv
// Restoring divider pipeline, one quotient bit per stage: floor(sq * 2^32 / sum).
module qan_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [3:0][59:0]     sq_i,
  input  logic [61:0]          den_i,
  input  qan_pkg::qan_side_t   side_i,
  output logic                 valid_o,
  output logic [3:0][32:0]     quo_o,
  output qan_pkg::qan_side_t   side_o
);
  import qan_pkg::*;

  logic [SumW-1:0] rem_q  [DivSteps][Lanes];
  logic [QuoW-1:0] quo_q  [DivSteps][Lanes];
  logic [SumW-1:0] den_q  [DivSteps];
  qan_side_t       side_q [DivSteps];
  logic [DivSteps-1:0] vld_q;

  for (genvar j = 0; j < DivSteps; j++) begin : g_step
    logic [SumW-1:0] rem_in [Lanes];
    logic [QuoW-1:0] quo_in [Lanes];
    logic            nb_in  [Lanes];
    logic [SumW-1:0] den_in;
    qan_side_t       side_in;
    logic            vld_in;
    logic [SumW:0]   trial  [Lanes];
    logic [SumW-1:0] rem_d  [Lanes];
    logic [QuoW-1:0] quo_d  [Lanes];

    if (j == 0) begin : g_head
      // The remainder starts at the top bits of sq * 2^32, known below the sum.
      always_comb begin
        for (int k = 0; k < Lanes; k++) begin
          rem_in[k] = SumW'(sq_i[k][SqW-1:1]);
          quo_in[k] = '0;
          nb_in[k]  = sq_i[k][0];
        end
        den_in  = den_i;
        side_in = side_i;
        vld_in  = valid_i;
      end
    end else begin : g_body
      always_comb begin
        for (int k = 0; k < Lanes; k++) begin
          rem_in[k] = rem_q[j-1][k];
          quo_in[k] = quo_q[j-1][k];
          nb_in[k]  = 1'b0;
        end
        den_in  = den_q[j-1];
        side_in = side_q[j-1];
        vld_in  = vld_q[j-1];
      end
    end

    always_comb begin
      for (int k = 0; k < Lanes; k++) begin
        trial[k] = {rem_in[k], nb_in[k]};
        if (trial[k] >= {1'b0, den_in}) begin
          rem_d[k] = SumW'(trial[k] - {1'b0, den_in});
          quo_d[k] = {quo_in[k][QuoW-2:0], 1'b1};
        end else begin
          rem_d[k] = SumW'(trial[k]);
          quo_d[k] = {quo_in[k][QuoW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        quo_q[j]  <= quo_d;
        den_q[j]  <= den_in;
        side_q[j] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      quo_o[k] = quo_q[DivSteps-1][k];
    end
  end

  assign side_o  = side_q[DivSteps-1];
  assign valid_o = vld_q[DivSteps-1];

endmodule

// File: rtl/core/qan_isqrt.sv
// Digit-by-digit integer square root pipeline, one root bit per stage.
module qan_isqrt (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [3:0][32:0]     rad_i,
  input  qan_pkg::qan_side_t   side_i,
  output logic                 valid_o,
  output logic [3:0][16:0]     root_o,
  output qan_pkg::qan_side_t   side_o
);
  import qan_pkg::*;

  logic [IsqRemW-1:0] rem_q  [IsqSteps][Lanes];
  logic [RootW-1:0]   root_q [IsqSteps][Lanes];
  qan_side_t          side_q [IsqSteps];
  logic [IsqSteps-1:0] vld_q;

  for (genvar j = 0; j < IsqSteps; j++) begin : g_step
    localparam int B = IsqSteps - 1 - j;

    logic [IsqRemW-1:0] rem_in  [Lanes];
    logic [RootW-1:0]   root_in [Lanes];
    qan_side_t          side_in;
    logic               vld_in;
    logic [IsqRemW-1:0] trial   [Lanes];
    logic [IsqRemW-1:0] rem_d   [Lanes];
    logic [RootW-1:0]   root_d  [Lanes];

    if (j == 0) begin : g_head
      always_comb begin
        for (int k = 0; k < Lanes; k++) begin
          rem_in[k]  = IsqRemW'(rad_i[k]);
          root_in[k] = '0;
        end
        side_in = side_i;
        vld_in  = valid_i;
      end
    end else begin : g_body
      always_comb begin
        for (int k = 0; k < Lanes; k++) begin
          rem_in[k]  = rem_q[j-1][k];
          root_in[k] = root_q[j-1][k];
        end
        side_in = side_q[j-1];
        vld_in  = vld_q[j-1];
      end
    end

    // Setting bit B of the root adds (2 * root + 2^B) * 2^B to its square.
    always_comb begin
      for (int k = 0; k < Lanes; k++) begin
        trial[k] = (IsqRemW'(root_in[k]) << (B + 1)) + (IsqRemW'(1) << (2 * B));
        if (rem_in[k] >= trial[k]) begin
          rem_d[k]  = rem_in[k] - trial[k];
          root_d[k] = root_in[k] | (RootW'(1) << B);
        end else begin
          rem_d[k]  = rem_in[k];
          root_d[k] = root_in[k];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
        side_q[j] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      root_o[k] = root_q[IsqSteps-1][k];
    end
  end

  assign side_o  = side_q[IsqSteps-1];
  assign valid_o = vld_q[IsqSteps-1];

endmodule

// File: rtl/core/quaternion_alu_normalized_unit.sv
// Top level of the normalized quaternion ALU: front end, divider, square root, output.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+----------------------------------
//   input   | in        | valid_i / stall_o   | func_i, a_x_i..a_w_i, b_x_i..b_w_i
//   result  | out       | valid_o / stall_i   | r_x_o..r_w_o, zero_length_o
//
// One item enters per cycle while stall_o is low; each result passes through
// six front-end stages, 33 divider stages (one quotient bit each), 17 square-root
// stages and the output register. Reset clears only the valid bits of every stage.
// A stalled result freezes the whole pipeline, and stall_o is raised in that
// same cycle, so the block holds every item in place until the result is taken.
module quaternion_alu_normalized_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic [1:0]         func_i,
  input  logic signed [17:0] a_x_i,
  input  logic signed [17:0] a_y_i,
  input  logic signed [17:0] a_z_i,
  input  logic signed [17:0] a_w_i,
  input  logic signed [17:0] b_x_i,
  input  logic signed [17:0] b_y_i,
  input  logic signed [17:0] b_z_i,
  input  logic signed [17:0] b_w_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [16:0] r_x_o,
  output logic signed [16:0] r_y_o,
  output logic signed [16:0] r_z_o,
  output logic signed [16:0] r_w_o,
  output logic               zero_length_o
);
  import qan_pkg::*;

  logic en;
  logic out_vld_q;

  assign en      = !(out_vld_q && stall_i);
  assign stall_o = !en;

  logic            fe_vld;
  logic [3:0][59:0] fe_sq;
  logic [61:0]     fe_sum;
  qan_side_t       fe_side;

  qan_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_i),
    .func_i  (func_i),
    .a_x_i   (a_x_i),
    .a_y_i   (a_y_i),
    .a_z_i   (a_z_i),
    .a_w_i   (a_w_i),
    .b_x_i   (b_x_i),
    .b_y_i   (b_y_i),
    .b_z_i   (b_z_i),
    .b_w_i   (b_w_i),
    .valid_o (fe_vld),
    .sq_o    (fe_sq),
    .sum_o   (fe_sum),
    .side_o  (fe_side)
  );

  logic             dv_vld;
  logic [3:0][32:0] dv_quo;
  qan_side_t        dv_side;

  qan_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fe_vld),
    .sq_i    (fe_sq),
    .den_i   (fe_sum),
    .side_i  (fe_side),
    .valid_o (dv_vld),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  logic             sr_vld;
  logic [3:0][16:0] sr_root;
  qan_side_t        sr_side;

  qan_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_vld),
    .rad_i   (dv_quo),
    .side_i  (dv_side),
    .valid_o (sr_vld),
    .root_o  (sr_root),
    .side_o  (sr_side)
  );

  // The rounded magnitude is the largest n with 2n - 1 not above the root.
  logic [16:0]        rnd    [Lanes];
  logic [16:0]        mag    [Lanes];
  logic signed [16:0] res_d  [Lanes];
  logic signed [16:0] res_q  [Lanes];
  logic               zero_d;
  logic               zero_q;

  always_comb begin
    for (int k = 0; k < Lanes; k++) begin
      rnd[k] = sr_root[k] + 17'd1;
      mag[k] = {1'b0, rnd[k][16:1]};
      if (sr_side.zero || sr_side.nop) begin
        res_d[k] = '0;
      end else if (sr_side.neg[k]) begin
        res_d[k] = -mag[k];
      end else begin
        res_d[k] = mag[k];
      end
    end
    zero_d = sr_side.zero && !sr_side.nop;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      zero_q <= zero_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= sr_vld;
    end
  end

  assign valid_o       = out_vld_q;
  assign r_x_o         = res_q[0];
  assign r_y_o         = res_q[1];
  assign r_z_o         = res_q[2];
  assign r_w_o         = res_q[3];
  assign zero_length_o = zero_q;

endmodule

// File: test/tb_quaternion_alu_normalized_unit.sv
// Self-checking testbench for the normalized quaternion ALU.
`timescale 1ns / 1ps

module tb_quaternion_alu_normalized_unit;
  import qan_pkg::*;

  localparam logic [1:0] FuncNone = 2'd3;
  localparam int unsigned PipeDepth = 57;

  typedef struct {
    logic signed [16:0] x, y, z, w;
    logic               zl;
  } unit_quat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               valid_i = 1'b0;
  logic               stall_o;
  logic [1:0]         func_i = FUNC_MUL;
  logic signed [17:0] a_x_i = '0, a_y_i = '0, a_z_i = '0, a_w_i = '0;
  logic signed [17:0] b_x_i = '0, b_y_i = '0, b_z_i = '0, b_w_i = '0;
  logic               valid_o;
  logic               stall_i = 1'b0;
  logic signed [16:0] r_x_o, r_y_o, r_z_o, r_w_o;
  logic               zero_length_o;

  unit_quat_t unit_quat_q[$];
  int         errors = 0;
  bit         quiet = 1'b0;
  bit         in_taken = 1'b0;

  quaternion_alu_normalized_unit u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // round(m * 2^15 / sqrt(s)) to nearest, ties away from zero.
  function automatic longint unsigned unit_mag(longint unsigned m, longint unsigned s);
    bit [127:0]      rhs;
    bit [127:0]      lhs;
    longint unsigned lo, hi, n, t;
    rhs = 128'(m * m) << 32;
    lo  = 0;
    hi  = 32768;
    while (lo < hi) begin
      n   = (lo + hi + 1) >> 1;
      t   = 2 * n - 1;
      lhs = 128'(t * t) * 128'(s);
      if (lhs <= rhs) lo = n;
      else hi = n - 1;
    end
    return lo;
  endfunction

  function automatic unit_quat_t normalize_quat(logic [1:0] f,
      logic signed [17:0] ax, ay, az, aw, bx, by, bz, bw);
    longint          c[4];
    longint unsigned m[4];
    longint unsigned big, s, v;
    int              sh;
    unit_quat_t      r;
    logic signed [16:0] o[4];
    r = '{0, 0, 0, 0, 1'b0};
    if (f == FuncNone) return r;
    case (f)
      FUNC_MUL: begin
        c[0] = aw * bx + ax * bw + ay * bz - az * by;
        c[1] = aw * by + ay * bw + az * bx - ax * bz;
        c[2] = aw * bz + az * bw + ax * by - ay * bx;
        c[3] = aw * bw - ax * bx - ay * by - az * bz;
      end
      FUNC_ADD: begin
        c[0] = (longint'(ax) + bx) * 32768;
        c[1] = (longint'(ay) + by) * 32768;
        c[2] = (longint'(az) + bz) * 32768;
        c[3] = (longint'(aw) + bw) * 32768;
      end
      default: begin
        c[0] = (longint'(ax) - bx) * 32768;
        c[1] = (longint'(ay) - by) * 32768;
        c[2] = (longint'(az) - bz) * 32768;
        c[3] = (longint'(aw) - bw) * 32768;
      end
    endcase
    big = 0;
    for (int i = 0; i < 4; i++) begin
      m[i] = (c[i] < 0) ? -c[i] : c[i];
      if (m[i] > big) big = m[i];
    end
    sh = 0;
    while ((big >> sh) >= (64'd1 << 30)) sh++;
    s = 0;
    for (int i = 0; i < 4; i++) begin
      m[i] = m[i] >> sh;
      s += m[i] * m[i];
    end
    if (s == 0) begin
      r.zl = 1'b1;
      return r;
    end
    for (int i = 0; i < 4; i++) begin
      v    = unit_mag(m[i], s);
      o[i] = (c[i] < 0) ? -17'(v) : 17'(v);
    end
    r.x = o[0];
    r.y = o[1];
    r.z = o[2];
    r.w = o[3];
    return r;
  endfunction

  // Accepted input items are predicted at the edge where they are taken.
  always @(posedge clk_i) begin
    in_taken <= valid_i && !stall_o;
    if (rst_ni && valid_i && !stall_o)
      unit_quat_q.push_back(normalize_quat(func_i, a_x_i, a_y_i, a_z_i, a_w_i,
                                           b_x_i, b_y_i, b_z_i, b_w_i));
  end

  always @(posedge clk_i) begin
    unit_quat_t e;
    if (rst_ni && valid_o && !stall_i) begin
      if (unit_quat_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d w=%0d zl=%0b", $realtime,
                 r_x_o, r_y_o, r_z_o, r_w_o, zero_length_o);
        errors++;
      end else begin
        e = unit_quat_q.pop_front();
        if (e.x !== r_x_o || e.y !== r_y_o || e.z !== r_z_o || e.w !== r_w_o ||
            e.zl !== zero_length_o) begin
          $display("%0t: mismatch expected x=%0d y=%0d z=%0d w=%0d zl=%0b", $realtime,
                   e.x, e.y, e.z, e.w, e.zl);
          $display("%0t:          actual   x=%0d y=%0d z=%0d w=%0d zl=%0b", $realtime,
                   r_x_o, r_y_o, r_z_o, r_w_o, zero_length_o);
          errors++;
        end
      end
    end
  end

  // Receiver stalls in random bursts until the quiet part of the run.
  initial begin
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(negedge clk_i);
        stall_i <= 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_quat(logic [1:0] f, logic signed [17:0] ax, ay, az, aw,
                           bx, by, bz, bw);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    valid_i <= 1'b1;
    func_i  <= f;
    a_x_i <= ax; a_y_i <= ay; a_z_i <= az; a_w_i <= aw;
    b_x_i <= bx; b_y_i <= by; b_z_i <= bz; b_w_i <= bw;
    do @(negedge clk_i); while (!in_taken);
  endtask

  function automatic logic signed [17:0] rand_comp();
    case ($urandom_range(0, 3))
      0:       return $signed(18'($urandom_range(0, 64))) - 18'sd32;
      1:       return $urandom_range(0, 1) ? 18'sh1FFFF : -18'sh20000;
      default: return 18'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] rand_func();
    int unsigned p;
    p = $urandom_range(0, 19);
    if (p == 0) return FuncNone;
    if (p < 8) return FUNC_MUL;
    if (p < 14) return FUNC_ADD;
    return FUNC_SUB;
  endfunction

  task automatic test_directed();
    logic signed [17:0] mx, mn;
    mx = 18'sh1FFFF;
    mn = -18'sh20000;
    send_quat(FUNC_MUL, mx, mx, mx, mx, mx, mx, mx, mx);
    send_quat(FUNC_MUL, mn, mn, mn, mn, mn, mn, mn, mn);
    send_quat(FUNC_MUL, mx, mn, mx, mn, mn, mx, mn, mx);
    send_quat(FUNC_ADD, mx, mx, mx, mx, mx, mx, mx, mx);
    send_quat(FUNC_ADD, mn, mn, mn, mn, mn, mn, mn, mn);
    send_quat(FUNC_SUB, mx, mn, mx, mn, mn, mx, mn, mx);
    send_quat(FUNC_SUB, mn, mx, mn, mx, mx, mn, mx, mn);
    // Zero length through multiply and subtract, and add operands that cancel in some components.
    send_quat(FUNC_MUL, 0, 0, 0, 0, mx, mn, 5, 7);
    send_quat(FUNC_ADD, 3, -9, mx, mn, -3, 9, -mx, 0);
    send_quat(FUNC_ADD, mx, mn, 1, -1, -mx, 0, -1, 1);
    send_quat(FUNC_SUB, mn, 77, -5, mx, mn, 77, -5, mx);
    // The spare operation code must give zeros with the flag low.
    send_quat(FuncNone, mx, mx, mx, mx, mx, mx, mx, mx);
    send_quat(FuncNone, 0, 0, 0, 0, 0, 0, 0, 0);
    // Unit vectors and one-bit values.
    send_quat(FUNC_MUL, 0, 0, 0, 18'sd32768, 18'sd32768, 0, 0, 0);
    send_quat(FUNC_MUL, 1, 0, 0, 0, 0, 1, 0, 0);
    send_quat(FUNC_ADD, 1, 1, 1, 1, 0, 0, 0, 0);
    send_quat(FUNC_SUB, 0, 0, 0, 0, 1, 0, 0, 0);
    send_quat(FUNC_ADD, 1, 2, 0, 0, 0, 0, 0, 0);
    send_quat(FUNC_MUL, -1, -1, -1, -1, 1, -1, 1, -1);
    send_quat(FUNC_ADD, 18'sh15555, -18'sh0AAAA, 18'sh0AAAA, -18'sh15556, 0, 0, 0, 0);
  endtask

  task automatic test_random(int count);
    logic [1:0]         f;
    logic signed [17:0] v[8];
    for (int k = 0; k < count; k++) begin
      f = rand_func();
      foreach (v[i]) v[i] = rand_comp();
      // Cancelling operands now and then to reach zero length.
      if ($urandom_range(0, 24) == 0) begin
        if (f == FUNC_ADD) for (int i = 0; i < 4; i++) v[i + 4] = -v[i];
        else for (int i = 0; i < 4; i++) v[i + 4] = v[i];
      end
      send_quat(f, v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    end
  endtask

  task automatic test_drain_pause();
    test_random(40);
    valid_i <= 1'b0;
    @(negedge clk_i);
    while (unit_quat_q.size() != 0) @(negedge clk_i);
    test_random(40);
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(600);
    test_drain_pause();
    test_random(300);
    quiet = 1'b1;
    test_random(120);
    valid_i <= 1'b0;
    while (unit_quat_q.size() != 0) @(negedge clk_i);
    repeat (PipeDepth + 10) @(negedge clk_i);
    if (errors == 0 && unit_quat_q.size() == 0) begin
      $display("PASS quaternion_alu_normalized_unit");
    end else begin
      $display("FAIL quaternion_alu_normalized_unit");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("FAIL quaternion_alu_normalized_unit");
    $finish;
  end

endmodule

// File: files.f
rtl/core/qan_pkg.sv
rtl/core/qan_front.sv
rtl/core/qan_div.sv
rtl/core/qan_isqrt.sv
rtl/core/quaternion_alu_normalized_unit.sv
test/tb_quaternion_alu_normalized_unit.sv
